### rtl/tcc_pkg.sv
// Shared types, codes and helpers of the terminal cursor controller.
// No dependencies; every other file but tcc_if imports this package.
package tcc_pkg;

    // Input command codes
    typedef enum logic [2:0] {
        MODE_PRINT = 3'd0,
        MODE_LF    = 3'd1,
        MODE_CR    = 3'd2,
        MODE_NEL   = 3'd3,
        MODE_ED    = 3'd4,
        MODE_EL    = 3'd5
    } mode_t;

    // Erase selectors
    localparam logic [7:0] ERASE_TO_END   = 8'd0;
    localparam logic [7:0] ERASE_TO_START = 8'd1;
    localparam logic [7:0] ERASE_ALL      = 8'd2;

    // Screen-store command codes
    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_GLYPH  = 3'd1,
        CMD_SCROLL = 3'd2,
        CMD_SEG    = 3'd3,
        CMD_RANGE  = 3'd4,
        CMD_FULL   = 3'd5
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_AUTOWRAP = 1'b0,
        REG_NEWLINE  = 1'b1
    } cfg_idx_t;

    // Decoded operation kinds handed from front to back
    typedef enum logic [3:0] {
        OP_NOP,
        OP_PRINT,
        OP_NEWROW,
        OP_CR,
        OP_ED_END,
        OP_ED_START,
        OP_ED_ALL,
        OP_EL_END,
        OP_EL_START,
        OP_EL_ALL
    } op_t;

    // Sequencer steps inside one operation
    typedef enum logic [1:0] {
        STEP_A,
        STEP_A_SCROLL,
        STEP_B,
        STEP_B_SCROLL
    } step_t;

    typedef struct packed {
        op_t        kind;
        logic       caret;   // control char: '^' then the mapped glyph
        logic       home;    // row advance also returns to column 0
        logic [7:0] glyph;   // final glyph (already mapped for caret form)
        logic [7:0] attr;
    } op_rec_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [4:0] row_first;
        logic [4:0] row_last;
        logic [6:0] col_first;
        logic [6:0] col_last;
        logic [7:0] glyph;
        logic [7:0] glyph_attr;
        logic [4:0] cursor_row_out;
        logic [6:0] cursor_col_out;
        logic       last;
    } res_t;

    localparam logic [7:0] CARET_CHAR = 8'h5E;  // '^'
    localparam logic [7:0] CARET_BASE = 8'h40;  // '@'
    localparam logic [7:0] CTRL_LIMIT = 8'd32;

    localparam int QUEUE_DEPTH = 2;

    // Result fields keep the low bits of a row or column
    function automatic logic [4:0] row_fld(logic [7:0] v);
        return v[4:0];
    endfunction

    function automatic logic [6:0] col_fld(logic [7:0] v);
        return v[6:0];
    endfunction

endpackage

### rtl/tcc_if.sv
// Valid/ready channel interfaces: command input, screen command output, config write.
// No dependencies.

interface tcc_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [7:0] char_code;
    logic [7:0] erase_sel;
    logic [7:0] char_attr;

    modport source (output valid, mode, char_code, erase_sel, char_attr, input ready);
    modport sink   (input valid, mode, char_code, erase_sel, char_attr, output ready);
endinterface

interface tcc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [4:0] row_first;
    logic [4:0] row_last;
    logic [6:0] col_first;
    logic [6:0] col_last;
    logic [7:0] glyph;
    logic [7:0] glyph_attr;
    logic [4:0] cursor_row_out;
    logic [6:0] cursor_col_out;
    logic       last;

    modport source (output valid, cmd, row_first, row_last, col_first, col_last, glyph,
                    glyph_attr, cursor_row_out, cursor_col_out, last, input ready);
    modport sink   (input valid, cmd, row_first, row_last, col_first, col_last, glyph,
                    glyph_attr, cursor_row_out, cursor_col_out, last, output ready);
endinterface

interface tcc_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [0:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/tcc_queue.sv
// Short FIFO of decoded operations between front and back.
// Depends on tcc_pkg.
module tcc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tcc_pkg::op_rec_t push_data,
    output logic             full,
    input  logic             pop,
    output tcc_pkg::op_rec_t pop_data,
    output logic             not_empty
);
    import tcc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    op_rec_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/tcc_front.sv
// Front end: takes command transactions and classifies them into operations.
// Depends on tcc_pkg, tcc_if and tcc_queue.
module tcc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             newline_mode,
    tcc_in_if.sink           req,
    input  logic             pop,
    output tcc_pkg::op_rec_t pop_data,
    output logic             not_empty
);
    import tcc_pkg::*;

    op_rec_t op;
    logic    q_full;

    always_comb
    begin
        op       = '0;
        op.kind  = OP_NOP;
        op.glyph = req.char_code;
        op.attr  = req.char_attr;
        case (req.mode)
            MODE_PRINT:
            begin
                op.kind = OP_PRINT;
                if (req.char_code < CTRL_LIMIT)
                begin
                    op.caret = 1'b1;
                    op.glyph = CARET_BASE + req.char_code;
                end
            end
            MODE_LF:
            begin
                op.kind = OP_NEWROW;
                op.home = newline_mode;
            end
            MODE_CR:  op.kind = OP_CR;
            MODE_NEL:
            begin
                op.kind = OP_NEWROW;
                op.home = 1'b1;
            end
            MODE_ED:
            begin
                case (req.erase_sel)
                    ERASE_TO_END:   op.kind = OP_ED_END;
                    ERASE_TO_START: op.kind = OP_ED_START;
                    ERASE_ALL:      op.kind = OP_ED_ALL;
                    default:        op.kind = OP_NOP;
                endcase
            end
            MODE_EL:
            begin
                case (req.erase_sel)
                    ERASE_TO_END:   op.kind = OP_EL_END;
                    ERASE_TO_START: op.kind = OP_EL_START;
                    ERASE_ALL:      op.kind = OP_EL_ALL;
                    default:        op.kind = OP_NOP;
                endcase
            end
            default:  op.kind = OP_NOP;
        endcase
    end

    assign req.ready = !q_full;

    tcc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (req.valid),
        .push_data (op),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (not_empty)
    );

endmodule

### rtl/tcc_back.sv
// Back end: owns the cursor and sequences each operation into screen commands.
// Depends on tcc_pkg and tcc_if.
module tcc_back #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             autowrap,
    input  logic             q_valid,
    input  tcc_pkg::op_rec_t q_op,
    output logic             q_pop,
    tcc_out_if.source        rsp
);
    import tcc_pkg::*;

    localparam int RW = $clog2(SCREEN_ROWS);
    localparam int CW = $clog2(SCREEN_COLUMNS);
    localparam logic [RW-1:0] LAST_ROW = RW'(SCREEN_ROWS - 1);
    localparam logic [CW-1:0] LAST_COL = CW'(SCREEN_COLUMNS - 1);

    logic            act_reg;
    step_t           step_reg, step_next;
    op_rec_t         op_reg;
    logic [RW-1:0]   row_reg, row_next;
    logic [CW-1:0]   col_reg, col_next;
    logic            out_valid_reg;
    res_t            res_reg, res;
    logic            res_last;
    logic            fire;
    logic            at_right, at_bottom, glyph_scroll, scroll_step;
    logic [7:0]      glyph_sel;

    assign at_right     = (col_reg == LAST_COL);
    assign at_bottom    = (row_reg == LAST_ROW);
    assign glyph_scroll = autowrap && at_right && at_bottom;
    assign scroll_step  = (step_reg == STEP_A_SCROLL) || (step_reg == STEP_B_SCROLL);
    assign glyph_sel    = (op_reg.caret && step_reg == STEP_A) ? CARET_CHAR : op_reg.glyph;

    assign fire  = act_reg && (!out_valid_reg || rsp.ready);
    assign q_pop = q_valid && (!act_reg || (fire && res_last));

    // Result and cursor update for the current step
    always_comb
    begin
        res      = '0;
        res.cmd  = CMD_NONE;
        row_next = row_reg;
        col_next = col_reg;
        case (op_reg.kind)
            OP_PRINT:
            begin
                if (scroll_step)
                begin
                    res.cmd = CMD_SCROLL;
                end
                else
                begin
                    res.cmd        = CMD_GLYPH;
                    res.row_first  = row_fld(8'(row_reg));
                    res.col_first  = col_fld(8'(col_reg));
                    res.glyph      = glyph_sel;
                    res.glyph_attr = op_reg.attr;
                    if (!at_right)
                    begin
                        col_next = col_reg + CW'(1);
                    end
                    else if (autowrap)
                    begin
                        col_next = '0;
                        if (!at_bottom)
                        begin
                            row_next = row_reg + RW'(1);
                        end
                    end
                end
            end
            OP_NEWROW:
            begin
                res.cmd = at_bottom ? CMD_SCROLL : CMD_NONE;
                if (!at_bottom)
                begin
                    row_next = row_reg + RW'(1);
                end
                if (op_reg.home)
                begin
                    col_next = '0;
                end
            end
            OP_CR:
            begin
                col_next = '0;
            end
            OP_ED_END:
            begin
                if (step_reg == STEP_A)
                begin
                    res.cmd       = CMD_SEG;
                    res.row_first = row_fld(8'(row_reg));
                    res.col_first = col_fld(8'(col_reg));
                    res.col_last  = col_fld(8'(LAST_COL));
                end
                else
                begin
                    res.cmd       = CMD_RANGE;
                    res.row_first = row_fld(8'(row_reg + RW'(1)));
                    res.row_last  = row_fld(8'(LAST_ROW));
                end
            end
            OP_ED_START:
            begin
                // rows above first, then the segment up to the cursor
                if (step_reg == STEP_A && row_reg != '0)
                begin
                    res.cmd      = CMD_RANGE;
                    res.row_last = row_fld(8'(row_reg - RW'(1)));
                end
                else
                begin
                    res.cmd       = CMD_SEG;
                    res.row_first = row_fld(8'(row_reg));
                    res.col_last  = col_fld(8'(col_reg));
                end
            end
            OP_ED_ALL:
            begin
                res.cmd  = CMD_FULL;
                row_next = '0;
                col_next = '0;
            end
            OP_EL_END:
            begin
                res.cmd       = CMD_SEG;
                res.row_first = row_fld(8'(row_reg));
                res.col_first = col_fld(8'(col_reg));
                res.col_last  = col_fld(8'(LAST_COL));
            end
            OP_EL_START:
            begin
                res.cmd       = CMD_SEG;
                res.row_first = row_fld(8'(row_reg));
                res.col_last  = col_fld(8'(col_reg));
            end
            OP_EL_ALL:
            begin
                res.cmd       = CMD_RANGE;
                res.row_first = row_fld(8'(row_reg));
                res.row_last  = row_fld(8'(row_reg));
            end
            default:
            begin
                res.cmd = CMD_NONE;
            end
        endcase
        res.cursor_row_out = row_fld(8'(row_next));
        res.cursor_col_out = col_fld(8'(col_next));
        res.last           = res_last;
    end

    // Step sequencing
    always_comb
    begin
        step_next = step_reg;
        res_last  = 1'b1;
        case (op_reg.kind)
            OP_PRINT:
            begin
                case (step_reg)
                    STEP_A:
                    begin
                        if (glyph_scroll)
                        begin
                            step_next = STEP_A_SCROLL;
                            res_last  = 1'b0;
                        end
                        else if (op_reg.caret)
                        begin
                            step_next = STEP_B;
                            res_last  = 1'b0;
                        end
                    end
                    STEP_A_SCROLL:
                    begin
                        if (op_reg.caret)
                        begin
                            step_next = STEP_B;
                            res_last  = 1'b0;
                        end
                    end
                    STEP_B:
                    begin
                        if (glyph_scroll)
                        begin
                            step_next = STEP_B_SCROLL;
                            res_last  = 1'b0;
                        end
                    end
                    default: res_last = 1'b1;
                endcase
            end
            OP_ED_END:
            begin
                if (step_reg == STEP_A && !at_bottom)
                begin
                    step_next = STEP_B;
                    res_last  = 1'b0;
                end
            end
            OP_ED_START:
            begin
                if (step_reg == STEP_A && row_reg != '0)
                begin
                    step_next = STEP_B;
                    res_last  = 1'b0;
                end
            end
            default: res_last = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg       <= 1'b0;
            step_reg      <= STEP_A;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
            if (q_pop)
            begin
                act_reg  <= 1'b1;
                step_reg <= STEP_A;
            end
            else if (fire)
            begin
                step_reg <= step_next;
                if (res_last)
                begin
                    act_reg <= 1'b0;
                end
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg <= q_op;
        end
        if (fire)
        begin
            res_reg <= res;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.cmd            = res_reg.cmd;
    assign rsp.row_first      = res_reg.row_first;
    assign rsp.row_last       = res_reg.row_last;
    assign rsp.col_first      = res_reg.col_first;
    assign rsp.col_last       = res_reg.col_last;
    assign rsp.glyph          = res_reg.glyph;
    assign rsp.glyph_attr     = res_reg.glyph_attr;
    assign rsp.cursor_row_out = res_reg.cursor_row_out;
    assign rsp.cursor_col_out = res_reg.cursor_col_out;
    assign rsp.last           = res_reg.last;

    // Cursor never leaves the screen
    a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg <= LAST_ROW) && (col_reg <= LAST_COL))
        else $error("cursor outside screen");

    // A scroll step only follows a wrap at the bottom-right corner; the cursor then sits bottom-left
    a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (act_reg && scroll_step) |-> (row_reg == LAST_ROW) && (col_reg == '0))
        else $error("scroll step with cursor off bottom-left");

    // Second glyph step only for caret-form prints
    a_second_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        (act_reg && op_reg.kind == OP_PRINT && step_reg == STEP_B) |-> op_reg.caret)
        else $error("second glyph on plain print");

    // Finishing an operation with work queued picks it up without a gap
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res_last && q_valid) |=> act_reg)
        else $error("back end idled with work queued");

endmodule

### rtl/terminal_cursor_controller.sv
// Path: a command transaction is written into the queue, then into the back end's
// operation register; each of its screen commands is registered in the output stage.
// Throughput: one screen command per cycle while rsp does not stall; an item gives
// one command up to three (caret print with a wrap-scroll), set by the back-end sequencer.
// Reset: cursor home (0,0), autowrap on, newline mode off, queue and output empty.
// Depends on tcc_pkg, tcc_if, tcc_front, tcc_queue and tcc_back.
module terminal_cursor_controller #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 24
) (
    input  logic       clk,
    input  logic       rst_n,
    tcc_in_if.sink     req,
    tcc_out_if.source  rsp,
    tcc_cfg_if.sink    cfg
);
    import tcc_pkg::*;

    // Mode registers; the user must write them only while the block is idle (not enforced here)
    logic    autowrap_reg, autowrap_next;
    logic    newline_reg, newline_next;

    // Front-to-back handoff
    logic    q_pop;
    logic    q_valid;
    op_rec_t q_op;

    // Config port never stalls
    assign cfg.ready = 1'b1;

    always_comb
    begin
        autowrap_next = autowrap_reg;
        newline_next  = newline_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_AUTOWRAP: autowrap_next = cfg.data[0];
                REG_NEWLINE:  newline_next  = cfg.data[0];
                default:      autowrap_next = autowrap_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            autowrap_reg <= 1'b1;
            newline_reg  <= 1'b0;
        end
        else
        begin
            autowrap_reg <= autowrap_next;
            newline_reg  <= newline_next;
        end
    end

    // Front: decode each transaction (caret mapping, erase selector, newline
    // mode) and park it in a short queue so input and output stall apart.
    tcc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .newline_mode (newline_reg),
        .req          (req),
        .pop          (q_pop),
        .pop_data     (q_op),
        .not_empty    (q_valid)
    );

    // Back: cursor state plus a small step sequencer that emits one screen command
    // per cycle, unless the output stalls, into a registered output stage.
    tcc_back #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .autowrap (autowrap_reg),
        .q_valid  (q_valid),
        .q_op     (q_op),
        .q_pop    (q_pop),
        .rsp      (rsp)
    );

endmodule

### bench/testbench.sv
// Self-checking bench for terminal_cursor_controller: directed and random commands,
// each result checked against a cursor/screen-command predictor held in the bench.
// Depends on tcc_pkg, tcc_if and the RTL of terminal_cursor_controller.
module testbench;
    import tcc_pkg::*;

    localparam int COLS         = 80;
    localparam int ROWS         = 24;
    localparam int CLK_PERIOD   = 20;
    localparam int LIMIT_CYCLES = 400000;

    // Mode codes that the block leaves unused; it answers them with a no-op
    localparam logic [2:0] MODE_RSVD6 = 3'd6;
    localparam logic [2:0] MODE_RSVD7 = 3'd7;
    // First erase selector value with no meaning
    localparam logic [7:0] ERASE_FIRST_UNUSED = 8'd3;

    logic clk;
    logic rst_n;

    tcc_in_if  req ();
    tcc_out_if rsp ();
    tcc_cfg_if cfg ();

    terminal_cursor_controller #(
        .SCREEN_COLUMNS(COLS),
        .SCREEN_ROWS   (ROWS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp),
        .cfg  (cfg)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the cursor and the two mode bits
    // ------------------------------------------------------------------
    logic wrap_on;
    logic nl_on;
    int   cur_row;
    int   cur_col;

    res_t run_buf[4];       // screen commands of one command transaction
    int   run_len;
    res_t screen_cmds_due[$];   // predicted screen commands, oldest first

    int   items_sent;
    int   results_seen;
    int   error_count;
    bit   calm;             // set: neither side inserts idle cycles

    // ------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Error reporting
    // ------------------------------------------------------------------
    task automatic flag_error(string msg);
        $display("ERROR t=%0t result %0d: %s", $time, results_seen, msg);
        error_count++;
    endtask

    task automatic cmp_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    // Append one screen command, tagged with the cursor as it stands now.
    function automatic void emit_cmd(cmd_t c, int rf, int rl, int cf, int cl, int g, int a);
        res_t r;
        r.cmd            = c;
        r.row_first      = rf[4:0];
        r.row_last       = rl[4:0];
        r.col_first      = cf[6:0];
        r.col_last       = cl[6:0];
        r.glyph          = g[7:0];
        r.glyph_attr     = a[7:0];
        r.cursor_row_out = cur_row[4:0];
        r.cursor_col_out = cur_col[6:0];
        r.last           = 1'b0;
        run_buf[run_len] = r;
        run_len++;
    endfunction

    // Glyph at the cursor, then advance; wrap or clamp per autowrap.
    // A wrap past the bottom row adds a scroll right after the glyph.
    function automatic void place_glyph(int g, int a);
        int  r;
        int  c;
        bit  scroll;
        r      = cur_row;
        c      = cur_col;
        scroll = 1'b0;
        cur_col++;
        if (wrap_on)
        begin
            if (cur_col >= COLS)
            begin
                cur_col = 0;
                cur_row++;
            end
            if (cur_row >= ROWS)
            begin
                scroll  = 1'b1;
                cur_row = ROWS - 1;
                cur_col = 0;
            end
        end
        else if (cur_col >= COLS)
        begin
            cur_col = COLS - 1;
        end
        emit_cmd(CMD_GLYPH, r, 0, c, 0, g, a);
        if (scroll)
            emit_cmd(CMD_SCROLL, 0, 0, 0, 0, 0, 0);
    endfunction

    // Line feed / next line: scroll instead of leaving the bottom row.
    function automatic void advance_row(bit home);
        bit scroll;
        scroll = 1'b0;
        cur_row++;
        if (cur_row >= ROWS)
        begin
            scroll  = 1'b1;
            cur_row = ROWS - 1;
        end
        if (home)
            cur_col = 0;
        emit_cmd(scroll ? CMD_SCROLL : CMD_NONE, 0, 0, 0, 0, 0, 0);
    endfunction

    function automatic void predict_screen_cmds(logic [2:0] mode, logic [7:0] ch,
                                                logic [7:0] sel, logic [7:0] attr);
        int row;
        int col;
        row     = cur_row;
        col     = cur_col;
        run_len = 0;
        case (mode)
            MODE_PRINT:
            begin
                // control characters go out in caret form, two glyphs
                if (ch < CTRL_LIMIT)
                begin
                    place_glyph(int'(CARET_CHAR), int'(attr));
                    place_glyph(int'(CARET_BASE + ch), int'(attr));
                end
                else
                begin
                    place_glyph(int'(ch), int'(attr));
                end
            end
            MODE_LF:  advance_row(nl_on);
            MODE_NEL: advance_row(1'b1);
            MODE_CR:
            begin
                cur_col = 0;
                emit_cmd(CMD_NONE, 0, 0, 0, 0, 0, 0);
            end
            MODE_ED:
            begin
                if (sel == ERASE_TO_END)
                begin
                    emit_cmd(CMD_SEG, row, 0, col, COLS - 1, 0, 0);
                    if (row + 1 < ROWS)
                        emit_cmd(CMD_RANGE, row + 1, ROWS - 1, 0, 0, 0, 0);
                end
                else if (sel == ERASE_TO_START)
                begin
                    // rows above only when there are any
                    if (row > 0)
                        emit_cmd(CMD_RANGE, 0, row - 1, 0, 0, 0, 0);
                    emit_cmd(CMD_SEG, row, 0, 0, col, 0, 0);
                end
                else if (sel == ERASE_ALL)
                begin
                    cur_row = 0;
                    cur_col = 0;
                    emit_cmd(CMD_FULL, 0, 0, 0, 0, 0, 0);
                end
                else
                begin
                    emit_cmd(CMD_NONE, 0, 0, 0, 0, 0, 0);
                end
            end
            MODE_EL:
            begin
                if (sel == ERASE_TO_END)
                    emit_cmd(CMD_SEG, row, 0, col, COLS - 1, 0, 0);
                else if (sel == ERASE_TO_START)
                    emit_cmd(CMD_SEG, row, 0, 0, col, 0, 0);
                else if (sel == ERASE_ALL)
                    emit_cmd(CMD_RANGE, row, row, 0, 0, 0, 0);
                else
                    emit_cmd(CMD_NONE, 0, 0, 0, 0, 0, 0);
            end
            default: emit_cmd(CMD_NONE, 0, 0, 0, 0, 0, 0);
        endcase
        run_buf[run_len - 1].last = 1'b1;
        for (int i = 0; i < run_len; i++)
            screen_cmds_due.push_back(run_buf[i]);
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------
    // Idle length: mostly none, often a few cycles, now and then a long stretch.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    // Mostly printable text; control characters (caret form) and high bytes
    // mixed in, and favored on the last column to hit the double-wrap corner.
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 7);
        if (cur_col == COLS - 1 && r < 4)
            return 8'($urandom_range(0, CTRL_LIMIT - 1));
        if (r == 0)
            return 8'($urandom_range(0, CTRL_LIMIT - 1));
        if (r == 1)
            return 8'($urandom_range(128, 255));
        return 8'($urandom_range(32, 126));
    endfunction

    function automatic logic [7:0] pick_erase_sel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return ERASE_TO_END;
        if (r < 65)
            return ERASE_TO_START;
        if (r < 80)
            return ERASE_ALL;
        return 8'($urandom_range(ERASE_FIRST_UNUSED, 255));
    endfunction

    // ------------------------------------------------------------------
    // Command channel driver
    // ------------------------------------------------------------------
    // Valid stays high across back-to-back transactions; it is only lowered
    // when a gap follows, so no step sees two assignments to it.
    task automatic send_item(logic [2:0] mode, logic [7:0] ch, logic [7:0] sel,
                             logic [7:0] attr);
        int gap;
        gap = calm ? 0 : gap_len();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.mode      <= mode;
        req.char_code <= ch;
        req.erase_sel <= sel;
        req.char_attr <= attr;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        predict_screen_cmds(mode, ch, sel, attr);
        items_sent++;
    endtask

    // Hold off until every predicted screen command has come back.
    task automatic wait_screen_idle();
        req.valid <= 1'b0;
        @(posedge clk);
        while (screen_cmds_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mode register write, only with the block idle.
    task automatic write_mode_reg(cfg_idx_t idx, logic val);
        wait_screen_idle();
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        if (idx == REG_AUTOWRAP)
            wrap_on = val;
        else
            nl_on = val;
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the checker
    // ------------------------------------------------------------------
    initial
    begin
        int hold;
        hold = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                rsp.ready <= 1'b0;
                hold--;
            end
            else
            begin
                rsp.ready <= 1'b1;
                if (!calm && $urandom_range(0, 2) == 0)
                    hold = gap_len();
            end
        end
    end

    always @(posedge clk)
    begin : check_screen_cmds
        res_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            results_seen++;
            if (screen_cmds_due.size() == 0)
            begin
                flag_error("screen command with none pending");
            end
            else
            begin
                want = screen_cmds_due.pop_front();
                cmp_field("cmd",            8'(rsp.cmd),            8'(want.cmd));
                cmp_field("row_first",      8'(rsp.row_first),      8'(want.row_first));
                cmp_field("row_last",       8'(rsp.row_last),       8'(want.row_last));
                cmp_field("col_first",      8'(rsp.col_first),      8'(want.col_first));
                cmp_field("col_last",       8'(rsp.col_last),       8'(want.col_last));
                cmp_field("glyph",          rsp.glyph,              want.glyph);
                cmp_field("glyph_attr",     rsp.glyph_attr,         want.glyph_attr);
                cmp_field("cursor_row_out", 8'(rsp.cursor_row_out), 8'(want.cursor_row_out));
                cmp_field("cursor_col_out", 8'(rsp.cursor_col_out), 8'(want.cursor_col_out));
                cmp_field("last",           8'(rsp.last),           8'(want.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Character extremes: caret form at both ends of the control range,
    // first printable, DEL, high bytes, attributes at both ends.
    task automatic test_print_extremes();
        send_item(MODE_PRINT, 8'd0,   rnd8(), 8'hFF);
        send_item(MODE_PRINT, 8'd31,  rnd8(), 8'h00);
        send_item(MODE_PRINT, 8'd32,  rnd8(), 8'h5A);
        send_item(MODE_PRINT, 8'd127, rnd8(), 8'hA5);
        send_item(MODE_PRINT, 8'd128, rnd8(), 8'h00);
        send_item(MODE_PRINT, 8'd255, rnd8(), 8'hFF);
    endtask

    // Row and column moves plus the unused mode codes (no-op transactions).
    task automatic test_cursor_moves();
        send_item(MODE_LF,     rnd8(), rnd8(), rnd8());
        send_item(MODE_CR,     rnd8(), rnd8(), rnd8());
        send_item(MODE_NEL,    rnd8(), rnd8(), rnd8());
        send_item(MODE_RSVD6, 8'hFF, 8'hFF, 8'hFF);
        send_item(MODE_RSVD7, 8'h00, 8'h00, 8'h00);
        send_item(MODE_PRINT, 8'h41, rnd8(), rnd8());
    endtask

    // Every erase flavor; erase-from-start is tried both below the top row
    // (range plus segment) and on the top row (segment only).
    task automatic test_erase_commands();
        send_item(MODE_ED, rnd8(), ERASE_TO_END,       rnd8());
        send_item(MODE_ED, rnd8(), ERASE_TO_START,     rnd8());
        send_item(MODE_EL, rnd8(), ERASE_TO_END,       rnd8());
        send_item(MODE_EL, rnd8(), ERASE_TO_START,     rnd8());
        send_item(MODE_EL, rnd8(), ERASE_ALL,          rnd8());
        send_item(MODE_EL, rnd8(), 8'hFF,              rnd8());
        send_item(MODE_ED, rnd8(), ERASE_FIRST_UNUSED, rnd8());
        send_item(MODE_ED, rnd8(), ERASE_ALL,          rnd8());
        send_item(MODE_ED, rnd8(), ERASE_TO_START,     rnd8());
        send_item(MODE_ED, rnd8(), ERASE_TO_END,       rnd8());
    endtask

    task automatic end_of_line();
        case ($urandom_range(0, 2))
            0:
            begin
                send_item(MODE_CR, rnd8(), rnd8(), rnd8());
                send_item(MODE_LF, rnd8(), rnd8(), rnd8());
            end
            1: send_item(MODE_NEL, rnd8(), rnd8(), rnd8());
            default: send_item(MODE_LF, rnd8(), rnd8(), rnd8());
        endcase
    endtask

    // Terminal-like traffic: lines of text (some long enough to wrap or clamp,
    // and to scroll once the cursor sits on the bottom row), row moves,
    // erases, and a little noise with unused modes or fully random fields.
    task automatic test_random_traffic(int budget);
        int         stop_at;
        int         kind;
        int         len;
        logic [2:0] m;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                len = ($urandom_range(0, 4) == 0) ? COLS + $urandom_range(0, 12)
                                                  : $urandom_range(1, 12);
                repeat (len) send_item(MODE_PRINT, pick_char(), rnd8(), rnd8());
                end_of_line();
            end
            else if (kind < 70)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    m = ($urandom_range(0, 1) == 0) ? MODE_LF : MODE_NEL;
                    send_item(m, rnd8(), rnd8(), rnd8());
                end
            end
            else if (kind < 85)
            begin
                m = ($urandom_range(0, 1) == 0) ? MODE_ED : MODE_EL;
                send_item(m, rnd8(), pick_erase_sel(), rnd8());
            end
            else if (kind < 95)
            begin
                send_item(MODE_CR, rnd8(), rnd8(), rnd8());
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                    m = ($urandom_range(0, 1) == 0) ? MODE_RSVD6 : MODE_RSVD7;
                else
                    m = 3'($urandom);
                send_item(m, rnd8(), rnd8(), rnd8());
            end
        end
    endtask

    // Random traffic under all four mode-register settings; one phase runs
    // with no idle cycles on either side. Each write waits for the block
    // to drain, which also covers the sender pausing for all results.
    task automatic test_settings_sweep();
        test_random_traffic(35);
        write_mode_reg(REG_AUTOWRAP, 1'b0);
        write_mode_reg(REG_NEWLINE,  1'b1);
        test_random_traffic(35);
        write_mode_reg(REG_AUTOWRAP, 1'b1);
        calm = 1'b1;
        test_random_traffic(35);
        calm = 1'b0;
        write_mode_reg(REG_NEWLINE,  1'b0);
        write_mode_reg(REG_AUTOWRAP, 1'b0);
        test_random_traffic(35);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        wrap_on      = 1'b1;
        nl_on        = 1'b0;
        cur_row      = 0;
        cur_col      = 0;
        run_len      = 0;
        items_sent   = 0;
        results_seen = 0;
        error_count  = 0;
        calm         = 1'b0;

        rst_n         <= 1'b0;
        req.valid     <= 1'b0;
        req.mode      <= MODE_PRINT;
        req.char_code <= 8'h00;
        req.erase_sel <= ERASE_TO_END;
        req.char_attr <= 8'h00;
        cfg.valid     <= 1'b0;
        cfg.index     <= REG_AUTOWRAP;
        cfg.data      <= 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_print_extremes();
        test_cursor_moves();
        test_erase_commands();
        test_settings_sweep();

        // drain, then a quiet tail to catch any extra screen command
        wait_screen_idle();
        repeat (20) @(posedge clk);
        if (screen_cmds_due.size() != 0)
            flag_error($sformatf("%0d screen commands never arrived", screen_cmds_due.size()));

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### terminal_cursor_controller.f
rtl/tcc_pkg.sv
rtl/tcc_if.sv
rtl/tcc_queue.sv
rtl/tcc_front.sv
rtl/tcc_back.sv
rtl/terminal_cursor_controller.sv
bench/testbench.sv
